@@ sv/aafu_pkg.sv @@
package aafu_pkg;

  typedef enum logic [5:0] {
    F_ADC = 6'd0, F_SBC = 6'd1, F_AND = 6'd2, F_ORA = 6'd3, F_EOR = 6'd4,
    F_CMP = 6'd5, F_CPX = 6'd6, F_CPY = 6'd7, F_BIT = 6'd8,
    F_LDA = 6'd9, F_LDX = 6'd10, F_LDY = 6'd11,
    F_STA = 6'd12, F_STX = 6'd13, F_STY = 6'd14,
    F_ASLA = 6'd15, F_LSRA = 6'd16, F_ROLA = 6'd17, F_RORA = 6'd18,
    F_ASLM = 6'd19, F_LSRM = 6'd20, F_ROLM = 6'd21, F_RORM = 6'd22,
    F_INC = 6'd23, F_DEC = 6'd24,
    F_INX = 6'd25, F_INY = 6'd26, F_DEX = 6'd27, F_DEY = 6'd28,
    F_TAX = 6'd29, F_TAY = 6'd30, F_TXA = 6'd31, F_TYA = 6'd32,
    F_TSX = 6'd33, F_TXS = 6'd34,
    F_CLC = 6'd35, F_SEC = 6'd36, F_CLD = 6'd37, F_SED = 6'd38,
    F_CLI = 6'd39, F_SEI = 6'd40, F_CLV = 6'd41, F_PHP = 6'd42, F_PLP = 6'd43,
    F_BPL = 6'd44, F_BMI = 6'd45, F_BVC = 6'd46, F_BVS = 6'd47,
    F_BCC = 6'd48, F_BCS = 6'd49, F_BNE = 6'd50, F_BEQ = 6'd51
  } func_t;

  typedef enum logic [3:0] {
    C_ARITH, C_LOGIC, C_CMP, C_BIT, C_LOAD, C_STORE, C_SHA, C_SHM,
    C_INCDEC, C_REG, C_FLAG, C_STACK, C_BRANCH, C_NOP
  } cls_t;

  typedef struct packed {
    logic [5:0] func;
    cls_t       cls;
    logic [7:0] operand;
  } uop_t;

  typedef struct packed {
    logic [7:0] result;
    logic       write_back;
    logic       branch_taken;
    logic [7:0] status_out;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] sp_out;
  } res_t;

  localparam logic [7:0] SP_RESET = 8'hFD;
  localparam logic [7:0] P_RESET  = 8'h24;
  localparam int FLG_C = 0;
  localparam int FLG_Z = 1;
  localparam int FLG_I = 2;
  localparam int FLG_D = 3;
  localparam int FLG_B = 4;
  localparam int FLG_U = 5;
  localparam int FLG_V = 6;
  localparam int FLG_N = 7;
  localparam int QDEPTH = 2;

endpackage

@@ sv/aafu_if.sv @@
interface aafu_in_if;
  logic                valid;
  logic                ready;
  logic [5:0]          func;
  logic [7:0]          operand;
  modport source (output valid, func, operand, input ready);
  modport sink   (input valid, func, operand, output ready);
endinterface

interface aafu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic       write_back;
  logic       branch_taken;
  logic [7:0] status_out;
  logic [7:0] acc_out;
  logic [7:0] x_out;
  logic [7:0] y_out;
  logic [7:0] sp_out;
  modport source (output valid, result, write_back, branch_taken, status_out,
                  acc_out, x_out, y_out, sp_out, input ready);
  modport sink   (input valid, result, write_back, branch_taken, status_out,
                  acc_out, x_out, y_out, sp_out, output ready);
endinterface

@@ sv/accumulator_alu_flag_unit_top.sv @@
// an input item passes through the queue and then the result register before it is valid at the output
// throughput: one item per cycle while the output is ready, set by the combinational alu and register update
// a 2-entry queue separates the classifier from the execute stage
// reset (rst_n low, synchronous): a=x=y=0, sp=0xfd, status=0x24, queue and
// result register empty
module accumulator_alu_flag_unit_top (
  input logic   clk,
  input logic   rst_n,
  aafu_in_if.sink    in_ch,
  aafu_out_if.source out_ch
);
  import aafu_pkg::*;

  logic q_valid, q_ready;
  uop_t q_uop;
  res_t res;

  aafu_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_func(in_ch.func), .in_operand(in_ch.operand),
    .q_valid, .q_ready, .q_uop
  );

  aafu_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_uop,
    .o_valid(out_ch.valid), .o_ready(out_ch.ready), .o_res(res)
  );

  assign out_ch.result       = res.result;
  assign out_ch.write_back   = res.write_back;
  assign out_ch.branch_taken = res.branch_taken;
  assign out_ch.status_out   = res.status_out;
  assign out_ch.acc_out      = res.acc_out;
  assign out_ch.x_out        = res.x_out;
  assign out_ch.y_out        = res.y_out;
  assign out_ch.sp_out       = res.sp_out;

  a_u_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status_out[FLG_U]) else $error("u flag clear");
  a_wb_res: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.write_back) |-> (out_ch.result == 8'd0))
    else $error("result without write-back");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.write_back && out_ch.branch_taken))
    else $error("write-back and branch together");
endmodule

@@ sv/aafu_front.sv @@
module aafu_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [5:0]       in_func,
  input  logic [7:0]       in_operand,
  output logic             q_valid,
  input  logic             q_ready,
  output aafu_pkg::uop_t   q_uop
);
  import aafu_pkg::*;

  uop_t mem_r [QDEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  cls_t cls;
  logic push, pop;

  always_comb begin
    case (in_func) inside
      [6'd0:6'd1]:   cls = C_ARITH;
      [6'd2:6'd4]:   cls = C_LOGIC;
      [6'd5:6'd7]:   cls = C_CMP;
      6'd8:          cls = C_BIT;
      [6'd9:6'd11]:  cls = C_LOAD;
      [6'd12:6'd14]: cls = C_STORE;
      [6'd15:6'd18]: cls = C_SHA;
      [6'd19:6'd22]: cls = C_SHM;
      [6'd23:6'd28]: cls = C_INCDEC;
      [6'd29:6'd34]: cls = C_REG;
      [6'd35:6'd41]: cls = C_FLAG;
      [6'd42:6'd43]: cls = C_STACK;
      [6'd44:6'd51]: cls = C_BRANCH;
      default:       cls = C_NOP;
    endcase
  end

  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_uop    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{func: in_func, cls: cls, operand: in_operand};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ sv/aafu_back.sv @@
module aafu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  aafu_pkg::uop_t q_uop,
  output logic           o_valid,
  input  logic           o_ready,
  output aafu_pkg::res_t o_res
);
  import aafu_pkg::*;

  logic [7:0] a_r, x_r, y_r, sp_r, p_r;
  logic [7:0] a_nxt, x_nxt, y_nxt, sp_nxt, p_nxt;
  logic       valid_r;
  res_t       res_r;
  logic [7:0] m, src, sh, wb_val, res;
  logic [8:0] sum;
  logic       wb, tk, go;
  logic [1:0] kind;

  assign q_ready = !valid_r || o_ready;
  assign go      = q_valid && q_ready;
  assign m       = q_uop.operand;
  assign o_valid = valid_r;
  assign o_res   = res_r;

  always_comb begin
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; sp_nxt = sp_r; p_nxt = p_r;
    res = 8'd0; wb = 1'b0; tk = 1'b0;
    sum = 9'd0; src = 8'd0; sh = 8'd0; wb_val = 8'd0;
    kind = 2'(q_uop.func - ((q_uop.cls == C_SHA) ? 6'd15 : 6'd19));
    src = (q_uop.cls == C_SHA) ? a_r : m;
    case (kind)
      2'd0: sh = {src[6:0], 1'b0};
      2'd1: sh = {1'b0, src[7:1]};
      2'd2: sh = {src[6:0], p_r[FLG_C]};
      default: sh = {p_r[FLG_C], src[7:1]};
    endcase
    case (q_uop.cls)
      C_ARITH: begin
        src = (q_uop.func == F_SBC) ? ~m : m;
        sum = {1'b0, a_r} + {1'b0, src} + {8'd0, p_r[FLG_C]};
        a_nxt = sum[7:0];
        p_nxt[FLG_C] = sum[8];
        p_nxt[FLG_V] = (a_r[7] ^ sum[7]) & (src[7] ^ sum[7]);
      end
      C_LOGIC: begin
        case (q_uop.func)
          F_AND:   a_nxt = a_r & m;
          F_ORA:   a_nxt = a_r | m;
          default: a_nxt = a_r ^ m;
        endcase
      end
      C_CMP: begin
        case (q_uop.func)
          F_CMP:   src = a_r;
          F_CPX:   src = x_r;
          default: src = y_r;
        endcase
        sum = {1'b0, src} - {1'b0, m};
        p_nxt[FLG_C] = !sum[8];
      end
      C_BIT: begin
        p_nxt[FLG_Z] = ((a_r & m) == 8'd0);
        p_nxt[FLG_V] = m[6];
        p_nxt[FLG_N] = m[7];
      end
      C_LOAD: begin
        case (q_uop.func)
          F_LDA:   a_nxt = m;
          F_LDX:   x_nxt = m;
          default: y_nxt = m;
        endcase
      end
      C_STORE: begin
        wb = 1'b1;
        case (q_uop.func)
          F_STA:   res = a_r;
          F_STX:   res = x_r;
          default: res = y_r;
        endcase
      end
      C_SHA: begin
        a_nxt = sh;
        p_nxt[FLG_C] = kind[0] ? a_r[0] : a_r[7];
      end
      C_SHM: begin
        res = sh; wb = 1'b1;
        p_nxt[FLG_C] = kind[0] ? m[0] : m[7];
      end
      C_INCDEC: begin
        case (q_uop.func)
          F_INC:   begin res = m + 8'd1; wb = 1'b1; end
          F_DEC:   begin res = m - 8'd1; wb = 1'b1; end
          F_INX:   x_nxt = x_r + 8'd1;
          F_INY:   y_nxt = y_r + 8'd1;
          F_DEX:   x_nxt = x_r - 8'd1;
          default: y_nxt = y_r - 8'd1;
        endcase
      end
      C_REG: begin
        case (q_uop.func)
          F_TAX:   x_nxt = a_r;
          F_TAY:   y_nxt = a_r;
          F_TXA:   a_nxt = x_r;
          F_TYA:   a_nxt = y_r;
          F_TSX:   x_nxt = sp_r;
          default: sp_nxt = x_r;
        endcase
      end
      C_FLAG: begin
        case (q_uop.func)
          F_CLC:   p_nxt[FLG_C] = 1'b0;
          F_SEC:   p_nxt[FLG_C] = 1'b1;
          F_CLD:   p_nxt[FLG_D] = 1'b0;
          F_SED:   p_nxt[FLG_D] = 1'b1;
          F_CLI:   p_nxt[FLG_I] = 1'b0;
          F_SEI:   p_nxt[FLG_I] = 1'b1;
          default: p_nxt[FLG_V] = 1'b0;
        endcase
      end
      C_STACK: begin
        if (q_uop.func == F_PHP) begin
          res = p_r | 8'h30; wb = 1'b1;
          sp_nxt = sp_r - 8'd1;
          p_nxt[FLG_B] = 1'b0;
        end else begin
          sp_nxt = sp_r + 8'd1;
          p_nxt = m;
        end
      end
      C_BRANCH: begin
        case (q_uop.func)
          F_BPL, F_BMI: tk = p_r[FLG_N];
          F_BVC, F_BVS: tk = p_r[FLG_V];
          F_BCC, F_BCS: tk = p_r[FLG_C];
          default:      tk = p_r[FLG_Z];
        endcase
        tk = tk ~^ q_uop.func[0];
      end
      default: ;
    endcase
    // n/z source per class
    case (q_uop.cls)
      C_CMP: wb_val = sum[7:0];
      C_SHM: wb_val = res;
      C_INCDEC: wb_val = wb ? res : ((q_uop.func == F_INX || q_uop.func == F_DEX)
                                     ? x_nxt : y_nxt);
      C_LOAD: wb_val = m;
      C_REG: wb_val = (q_uop.func == F_TXA || q_uop.func == F_TYA) ? a_nxt : x_nxt;
      default: wb_val = a_nxt;
    endcase
    if (q_uop.func == F_TAY || q_uop.func == F_TYA) wb_val = (q_uop.func == F_TAY)
                                                            ? y_nxt : a_nxt;
    case (q_uop.cls)
      C_ARITH, C_LOGIC, C_CMP, C_LOAD, C_SHA, C_SHM, C_INCDEC: begin
        p_nxt[FLG_Z] = (wb_val == 8'd0);
        p_nxt[FLG_N] = wb_val[7];
      end
      C_REG: if (q_uop.func != F_TXS) begin
        p_nxt[FLG_Z] = (wb_val == 8'd0);
        p_nxt[FLG_N] = wb_val[7];
      end
      default: ;
    endcase
    p_nxt[FLG_U] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= 8'd0; x_r <= 8'd0; y_r <= 8'd0;
      sp_r <= SP_RESET; p_r <= P_RESET;
      valid_r <= 1'b0;
    end else begin
      if (go) begin
        a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; sp_r <= sp_nxt; p_r <= p_nxt;
      end
      if (q_ready) valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) res_r <= '{result: res, write_back: wb, branch_taken: tk,
                       status_out: p_nxt, acc_out: a_nxt, x_out: x_nxt,
                       y_out: y_nxt, sp_out: sp_nxt};
  end
endmodule

@@ verif/accumulator_alu_flag_unit_top_tb.sv @@
`timescale 1ns / 100ps

module accumulator_alu_flag_unit_top_tb;
  import aafu_pkg::*;

  typedef struct {
    logic [5:0] func;
    logic [7:0] operand;
  } op_item_t;

  logic clk;
  logic rst_n;

  aafu_in_if  in_ch();
  aafu_out_if out_ch();

  accumulator_alu_flag_unit_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  op_item_t   pending_ops[$];
  res_t       expected_regs[$];
  logic [7:0] acc_q, x_q, y_q, sp_q, p_q;
  int         errors;
  int         mismatches;
  int         sent;
  int         received;
  int         wb_count;
  int         taken_count;
  int         cycles;
  bit         quiet_mode;
  bit         hold_off;
  bit         in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] with_nz(logic [7:0] p, logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[FLG_Z] = (v == 8'h00);
    q[FLG_N] = v[7];
    return q;
  endfunction

  // executes one operation on the shadow cpu state and builds the expected result
  function automatic res_t execute_op(op_item_t it);
    res_t r;
    logic [8:0] sum;
    logic [7:0] m, s, v;
    logic cin;
    m = it.operand;
    s = p_q;
    cin = p_q[FLG_C];
    r = '0;
    case (it.func)
      F_ADC, F_SBC: begin
        if (it.func == F_SBC) m = ~m;
        sum = {1'b0, acc_q} + {1'b0, m} + {8'h00, cin};
        p_q[FLG_C] = sum[8];
        p_q[FLG_V] = (acc_q[7] ^ sum[7]) & (m[7] ^ sum[7]);
        acc_q = sum[7:0];
        p_q = with_nz(p_q, acc_q);
      end
      F_AND: begin acc_q = acc_q & m; p_q = with_nz(p_q, acc_q); end
      F_ORA: begin acc_q = acc_q | m; p_q = with_nz(p_q, acc_q); end
      F_EOR: begin acc_q = acc_q ^ m; p_q = with_nz(p_q, acc_q); end
      F_CMP: begin p_q[FLG_C] = acc_q >= m; p_q = with_nz(p_q, acc_q - m); end
      F_CPX: begin p_q[FLG_C] = x_q >= m; p_q = with_nz(p_q, x_q - m); end
      F_CPY: begin p_q[FLG_C] = y_q >= m; p_q = with_nz(p_q, y_q - m); end
      F_BIT: begin
        p_q[FLG_Z] = (acc_q & m) == 8'h00;
        p_q[FLG_V] = m[6];
        p_q[FLG_N] = m[7];
      end
      F_LDA: begin acc_q = m; p_q = with_nz(p_q, m); end
      F_LDX: begin x_q = m; p_q = with_nz(p_q, m); end
      F_LDY: begin y_q = m; p_q = with_nz(p_q, m); end
      F_STA: begin r.result = acc_q; r.write_back = 1'b1; end
      F_STX: begin r.result = x_q; r.write_back = 1'b1; end
      F_STY: begin r.result = y_q; r.write_back = 1'b1; end
      F_ASLA, F_LSRA, F_ROLA, F_RORA, F_ASLM, F_LSRM, F_ROLM, F_RORM: begin
        if (it.func <= F_RORA) m = acc_q;
        case (it.func)
          F_ASLA, F_ASLM: begin v = {m[6:0], 1'b0}; p_q[FLG_C] = m[7]; end
          F_LSRA, F_LSRM: begin v = {1'b0, m[7:1]}; p_q[FLG_C] = m[0]; end
          F_ROLA, F_ROLM: begin v = {m[6:0], cin}; p_q[FLG_C] = m[7]; end
          default:        begin v = {cin, m[7:1]}; p_q[FLG_C] = m[0]; end
        endcase
        p_q = with_nz(p_q, v);
        if (it.func <= F_RORA) begin
          acc_q = v;
        end else begin
          r.result = v;
          r.write_back = 1'b1;
        end
      end
      F_INC: begin r.result = m + 8'd1; r.write_back = 1'b1; p_q = with_nz(p_q, r.result); end
      F_DEC: begin r.result = m - 8'd1; r.write_back = 1'b1; p_q = with_nz(p_q, r.result); end
      F_INX: begin x_q = x_q + 8'd1; p_q = with_nz(p_q, x_q); end
      F_INY: begin y_q = y_q + 8'd1; p_q = with_nz(p_q, y_q); end
      F_DEX: begin x_q = x_q - 8'd1; p_q = with_nz(p_q, x_q); end
      F_DEY: begin y_q = y_q - 8'd1; p_q = with_nz(p_q, y_q); end
      F_TAX: begin x_q = acc_q; p_q = with_nz(p_q, x_q); end
      F_TAY: begin y_q = acc_q; p_q = with_nz(p_q, y_q); end
      F_TXA: begin acc_q = x_q; p_q = with_nz(p_q, acc_q); end
      F_TYA: begin acc_q = y_q; p_q = with_nz(p_q, acc_q); end
      F_TSX: begin x_q = sp_q; p_q = with_nz(p_q, x_q); end
      F_TXS: sp_q = x_q;
      F_CLC: p_q[FLG_C] = 1'b0;
      F_SEC: p_q[FLG_C] = 1'b1;
      F_CLD: p_q[FLG_D] = 1'b0;
      F_SED: p_q[FLG_D] = 1'b1;
      F_CLI: p_q[FLG_I] = 1'b0;
      F_SEI: p_q[FLG_I] = 1'b1;
      F_CLV: p_q[FLG_V] = 1'b0;
      F_PHP: begin
        r.result = p_q | 8'h30;
        r.write_back = 1'b1;
        sp_q = sp_q - 8'd1;
        p_q[FLG_B] = 1'b0;
      end
      F_PLP: begin sp_q = sp_q + 8'd1; p_q = m; end
      F_BPL: r.branch_taken = !s[FLG_N];
      F_BMI: r.branch_taken = s[FLG_N];
      F_BVC: r.branch_taken = !s[FLG_V];
      F_BVS: r.branch_taken = s[FLG_V];
      F_BCC: r.branch_taken = !s[FLG_C];
      F_BCS: r.branch_taken = s[FLG_C];
      F_BNE: r.branch_taken = !s[FLG_Z];
      F_BEQ: r.branch_taken = s[FLG_Z];
      default: ;
    endcase
    p_q[FLG_U] = 1'b1;
    r.status_out = p_q;
    r.acc_out = acc_q;
    r.x_out = x_q;
    r.y_out = y_q;
    r.sp_out = sp_q;
    return r;
  endfunction

  function automatic op_item_t mk(logic [5:0] f, logic [7:0] m);
    op_item_t it;
    it.func = f;
    it.operand = m;
    return it;
  endfunction

  // input transfer seen at the rising edge, used by the driver on the next falling edge
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
  end

  // driver: presents pending ops, updates the prediction on each transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_taken) begin
        expected_regs.push_back(execute_op(pending_ops.pop_front()));
        sent++;
      end
      if (in_ch.valid && !in_taken) begin
        // keep the current item until it is taken
      end else if (pending_ops.size() > 0 && !hold_off &&
                   (quiet_mode || $urandom_range(99) >= 11)) begin
        in_ch.valid   <= 1'b1;
        in_ch.func    <= pending_ops[0].func;
        in_ch.operand <= pending_ops[0].operand;
      end else begin
        in_ch.valid   <= 1'b0;
        in_ch.func    <= 6'($urandom);
        in_ch.operand <= 8'($urandom);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet_mode || ($urandom_range(99) >= 11);
  end

  // monitor
  always @(posedge clk) begin
    res_t got, exp_r;
    cycles++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.result = out_ch.result;
      got.write_back = out_ch.write_back;
      got.branch_taken = out_ch.branch_taken;
      got.status_out = out_ch.status_out;
      got.acc_out = out_ch.acc_out;
      got.x_out = out_ch.x_out;
      got.y_out = out_ch.y_out;
      got.sp_out = out_ch.sp_out;
      received++;
      if (got.write_back) wb_count++;
      if (got.branch_taken) taken_count++;
      if (expected_regs.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result transfer: %p", got);
        mismatches++;
      end else begin
        exp_r = expected_regs.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch at result %0d\n  expected %p\n  actual   %p",
                     received, exp_r, got);
          mismatches++;
        end
      end
    end
  end

  initial begin
    op_item_t it;
    int n;
    int f;
    errors = 0;
    mismatches = 0;
    sent = 0;
    received = 0;
    wb_count = 0;
    taken_count = 0;
    cycles = 0;
    quiet_mode = 1'b0;
    hold_off = 1'b0;
    in_taken = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.operand = '0;
    out_ch.ready = 1'b0;
    acc_q = 8'h00;
    x_q = 8'h00;
    y_q = 8'h00;
    sp_q = SP_RESET;
    p_q = P_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: operand extremes, overflow cases, stack wrap, plp of all ones
    pending_ops.push_back(mk(F_LDA, 8'h7F));
    pending_ops.push_back(mk(F_ADC, 8'h01));
    pending_ops.push_back(mk(F_SEC, 8'h00));
    pending_ops.push_back(mk(F_SBC, 8'hFF));
    pending_ops.push_back(mk(F_ADC, 8'h80));
    pending_ops.push_back(mk(F_BIT, 8'hC0));
    pending_ops.push_back(mk(F_BVS, 8'h00));
    pending_ops.push_back(mk(F_ROLM, 8'h80));
    pending_ops.push_back(mk(F_RORA, 8'h00));
    pending_ops.push_back(mk(F_INC, 8'hFF));
    pending_ops.push_back(mk(F_DEC, 8'h00));
    pending_ops.push_back(mk(F_BEQ, 8'h00));
    pending_ops.push_back(mk(F_LDX, 8'h00));
    pending_ops.push_back(mk(F_TXS, 8'h00));
    pending_ops.push_back(mk(F_PHP, 8'h00));
    pending_ops.push_back(mk(F_PLP, 8'hFF));
    pending_ops.push_back(mk(F_PLP, 8'h00));
    pending_ops.push_back(mk(F_TSX, 8'h00));
    pending_ops.push_back(mk(F_CPX, 8'h01));
    pending_ops.push_back(mk(F_SED, 8'h00));
    pending_ops.push_back(mk(6'd63, 8'hAA));
    pending_ops.push_back(mk(6'd52, 8'h55));
    pending_ops.push_back(mk(F_STA, 8'h00));
    // every selector once, including unused codes
    for (f = 0; f < 64; f++) pending_ops.push_back(mk(6'(f), 8'($urandom)));

    wait (pending_ops.size() == 0);
    hold_off = 1'b1;
    wait (expected_regs.size() == 0);
    @(negedge clk) hold_off = 1'b0;

    for (n = 0; n < 1900; n++) begin
      if (n == 600) quiet_mode = 1'b1;
      if (n == 900) quiet_mode = 1'b0;
      it.func = ($urandom_range(19) == 0) ? 6'($urandom_range(63, 52))
                                          : 6'($urandom_range(51));
      case ($urandom_range(3))
        0: it.operand = $urandom_range(1) ? 8'hFF : 8'h00;
        1: it.operand = $urandom_range(1) ? 8'h7F : 8'h80;
        default: it.operand = 8'($urandom);
      endcase
      pending_ops.push_back(it);
      if (pending_ops.size() > 32) wait (pending_ops.size() < 16);
    end

    wait (pending_ops.size() == 0 && expected_regs.size() == 0);
    repeat (10) @(posedge clk);
    $display("%0d operations sent, %0d results checked (%0d stores, %0d taken branches)",
             sent, received, wb_count, taken_count);
    if (errors == 0 && expected_regs.size() == 0) $display("[ OK ] regression clean");
    else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    wait (cycles >= 200000);
    $display("timeout with %0d results outstanding", expected_regs.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
